/* design/record_sort_by_key_quartiles_assert.svh */
// Assertion macros used by the checker file rsq_checker.sv.
`ifndef RECORD_SORT_BY_KEY_QUARTILES_ASSERT_SVH
`define RECORD_SORT_BY_KEY_QUARTILES_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rsq_pkg.sv */
package rsq_pkg;

  localparam int MAX_RECORDS_DEFAULT = 64;
  localparam int KEY_W = 8;
  localparam int TAG_W = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // compare-swap result: lower record is retired, higher one bubbles on
  typedef struct packed {
    rec_t low;
    rec_t high;
  } swap_t;

endpackage

/* design/rsq_store.sv */
module rsq_store #(
  parameter int DEPTH = rsq_pkg::MAX_RECORDS_DEFAULT,
  parameter int IW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  rsq_pkg::rec_t wdata,
  input  logic [IW-1:0] raddr,
  output rsq_pkg::rec_t rdata
);

  rsq_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/rsq_cmp_swap.sv */
module rsq_cmp_swap (
  input  rsq_pkg::rec_t  carry,
  input  rsq_pkg::rec_t  incoming,
  output rsq_pkg::swap_t result
);

  // strict compare keeps equal keys in arrival order
  always_comb begin
    if (carry.key > incoming.key) begin
      result.low  = incoming;
      result.high = carry;
    end else begin
      result.low  = carry;
      result.high = incoming;
    end
  end

endmodule

/* design/record_sort_by_key_quartiles.sv */
// Channel  Dir  Handshake              Payload
// -------  ---  ---------------------  ----------------------------------------------------------
// command  in   start & !busy          age_key, record_tag, last_record
// result   out  strobe, no stall       sorted_key, sorted_tag, quartile, dropped_flag, end_of_set
//
// Records are loaded while idle. The record with last_record set closes the set;
// busy then stays high while the single compare-swap unit sorts the store, each
// compare step costing one store read and one store write. Then the results are
// emitted; the final result shows on the cycle busy falls. Synchronous rst returns
// the block to loading with an empty set; results cannot be stalled by the receiver.
module record_sort_by_key_quartiles #(
  parameter int MAX_RECORDS = rsq_pkg::MAX_RECORDS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [rsq_pkg::KEY_W-1:0] age_key,
  input  logic [rsq_pkg::TAG_W-1:0] record_tag,
  input  logic                      last_record,
  output logic                      strobe,
  output logic [rsq_pkg::KEY_W-1:0] sorted_key,
  output logic [rsq_pkg::TAG_W-1:0] sorted_tag,
  output logic [1:0]                quartile,
  output logic                      dropped_flag,
  output logic                      end_of_set
);

  localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1; // store index
  localparam int CW = $clog2(MAX_RECORDS + 1);                      // record count

  typedef enum logic [2:0] {
    IDLE,       // loading records
    SORT_RD0,   // fetch entry 0 for the first pass
    SORT_LOAD,  // entry 0 becomes the bubbling record
    SORT_STEP,  // one compare-swap per cycle
    SORT_END,   // retire the bubbled record at the pass end
    EMIT_RD,    // fetch entry 0 for output
    EMIT        // one result per cycle
  } state_t;

  state_t        state;
  logic [CW-1:0] count;       // records stored in this set
  logic          overflow;    // a record of this set was dropped
  logic [IW-1:0] pos;         // compare position, then output position
  logic [IW-1:0] pass_end;    // last position of the current pass
  logic [IW-1:0] last_idx;    // n - 1
  logic [CW-1:0] q1, q2, q3;  // quartile bounds n/4, n/2, 3n/4
  rsq_pkg::rec_t carry;       // record bubbling through the pass

  logic          room;
  logic [CW-1:0] count_next;
  logic [CW+1:0] three_n;

  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  rsq_pkg::rec_t wdata;
  rsq_pkg::rec_t rdata;
  rsq_pkg::rec_t in_rec;
  rsq_pkg::swap_t swap;
  logic [1:0]    quart_now;

  assign busy       = (state != IDLE);
  assign room       = (count < CW'(MAX_RECORDS));
  assign count_next = room ? count + CW'(1) : count;
  assign three_n    = {2'b00, count_next} + {1'b0, count_next, 1'b0};
  assign in_rec     = '{key: age_key, tag: record_tag};

  rsq_store #(
    .DEPTH (MAX_RECORDS),
    .IW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rsq_cmp_swap u_cmp (
    .carry    (carry),
    .incoming (rdata),
    .result   (swap)
  );

  // Store port steering: loads in IDLE, retired records while sorting.
  always_comb begin
    we    = 1'b0;
    waddr = count[IW-1:0];
    wdata = in_rec;
    unique case (state)
      IDLE: begin
        we = start && room;
      end
      SORT_STEP: begin
        we    = 1'b1;
        waddr = pos;
        wdata = swap.low;
      end
      SORT_END: begin
        we    = 1'b1;
        waddr = pass_end;
        wdata = carry;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Read one ahead; the registered read data lands with the next state.
  always_comb begin
    unique case (state)
      SORT_LOAD: raddr = IW'(1);
      SORT_STEP: raddr = pos + IW'(2);
      EMIT:      raddr = pos + IW'(1);
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    if (CW'(pos) < q1) begin
      quart_now = 2'd0;
    end else if (CW'(pos) < q2) begin
      quart_now = 2'd1;
    end else if (CW'(pos) < q3) begin
      quart_now = 2'd2;
    end else begin
      quart_now = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      overflow <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            count <= count_next;
            if (!room) begin
              overflow <= 1'b1;
            end
            if (last_record) begin
              // close the set: count_next is at least one here
              last_idx <= IW'(count_next - CW'(1));
              pass_end <= IW'(count_next - CW'(1));
              q1       <= count_next >> 2;
              q2       <= count_next >> 1;
              q3       <= three_n[CW+1:2];
              state    <= (count_next > CW'(1)) ? SORT_RD0 : EMIT_RD;
            end
          end
        end
        SORT_RD0: begin
          state <= SORT_LOAD;
        end
        SORT_LOAD: begin
          carry <= rdata;
          pos   <= '0;
          state <= SORT_STEP;
        end
        SORT_STEP: begin
          carry <= swap.high;
          if (pos + IW'(1) == pass_end) begin
            state <= SORT_END;
          end else begin
            pos <= pos + IW'(1);
          end
        end
        SORT_END: begin
          if (pass_end == IW'(1)) begin
            state <= EMIT_RD;
          end else begin
            pass_end <= pass_end - IW'(1);
            state    <= SORT_LOAD;  // entry 0 was fetched this cycle
          end
        end
        EMIT_RD: begin
          pos   <= '0;
          state <= EMIT;
        end
        EMIT: begin
          strobe       <= 1'b1;
          sorted_key   <= rdata.key;
          sorted_tag   <= rdata.tag;
          quartile     <= quart_now;
          dropped_flag <= overflow;
          end_of_set   <= (pos == last_idx);
          if (pos == last_idx) begin
            count    <= '0;
            overflow <= 1'b0;
            state    <= IDLE;
          end else begin
            pos <= pos + IW'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* design/rsq_checker.sv */
`include "record_sort_by_key_quartiles_assert.svh"

module rsq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      busy,
  input logic                      strobe,
  input logic [rsq_pkg::KEY_W-1:0] sorted_key,
  input logic [1:0]                quartile,
  input logic                      dropped_flag,
  input logic                      end_of_set
);

  `RSQ_ASSERT_NOW(a_busy_mid_set, clk, rst, strobe && !end_of_set, busy, "idle mid set")
  `RSQ_ASSERT_NOW(a_idle_at_end, clk, rst, strobe && end_of_set, !busy, "busy after set end")
  `RSQ_ASSERT_NEXT(a_contiguous, clk, rst, strobe && !end_of_set, strobe, "gap in results")
  `RSQ_ASSERT_NEXT(a_ascending, clk, rst, strobe && !end_of_set, (sorted_key >= $past(sorted_key)) && (quartile >= $past(quartile)) && (dropped_flag == $past(dropped_flag)), "order broken")

endmodule

bind record_sort_by_key_quartiles rsq_checker u_rsq_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .strobe       (strobe),
  .sorted_key   (sorted_key),
  .quartile     (quartile),
  .dropped_flag (dropped_flag),
  .end_of_set   (end_of_set)
);
